@@ sv/sfd_pkg.sv @@
// Shared types and frame constants of the sample frame deframer.
package sfd_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALT    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER      = 2'd0,
        KIND_SAMPLE      = 2'd1,
        KIND_PROTO_ERR   = 2'd2,
        KIND_PARAM_ERR   = 2'd3
    } kind_t;

    localparam logic [31:0] FRAME_MAGIC     = 32'h4E41_5344;
    localparam logic [31:0] FRAME_VERSION   = 32'd1;
    localparam logic [5:0]  HEADER_LAST     = 6'd43;
    localparam logic [5:0]  HEADER_KEPT     = 6'd24;
    localparam logic [20:0] POINT_CAP       = 21'd1048576;
    localparam logic [20:0] MAX_POINTS_RST  = 21'd4096;

endpackage

@@ sv/sample_frame_deframer.sv @@
// Sample frame deframer: header check and 8-byte sample extraction from a byte stream.
//
// The block takes one byte item per clock cycle while in_ready is high: all header,
// counter and sample work is done between the state registers and a single result
// register. A header result is registered when the 44th header byte is accepted and
// appears in the next cycle; a sample result likewise after the eighth byte of the
// sample. Input is taken whenever the result register is empty or is being read in the
// same cycle, so the rate drops below one byte per cycle only while the output side
// holds off a waiting result. After a protocol or parameter error the block keeps
// accepting bytes but drops them until reset.
module sample_frame_deframer
    import sfd_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [63:0] timestamp_ms,
    output logic [20:0] point_count,
    output logic [3:0]  channel_index,
    output logic [19:0] point_index,
    output logic [63:0] sample_bits,
    output logic        last_of_frame
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
    localparam logic [31:0] CH_COUNT = 32'(CHANNELS);

    // Control state
    phase_t          phase_reg, phase_next;
    logic [5:0]      hdr_cnt_reg, hdr_cnt_next;
    logic [2:0]      smp_cnt_reg, smp_cnt_next;
    logic [CH_W-1:0] chan_reg, chan_next;
    logic [19:0]     point_reg, point_next;
    logic [20:0]     frame_pts_reg, frame_pts_next;
    logic [20:0]     max_points_reg;
    logic            out_valid_reg, out_valid_next;

    // Payload state
    logic [191:0]    hdr_reg, hdr_next;
    logic [63:0]     shift_reg, shift_next;

    // Result register
    kind_t           kind_reg, kind_next;
    logic [63:0]     ts_reg, ts_next;
    logic [20:0]     pcount_reg, pcount_next;
    logic [3:0]      chidx_reg, chidx_next;
    logic [19:0]     pidx_reg, pidx_next;
    logic [63:0]     bits_reg, bits_next;
    logic            last_reg, last_next;

    logic            accept;
    logic            emit;
    logic [191:0]    hdr_full;
    logic [31:0]     hdr_magic, hdr_version, hdr_chans, hdr_points;
    logic [20:0]     limit;
    logic            proto_bad, param_bad;
    logic            header_done, sample_done, frame_last;
    logic [63:0]     sample_word;
    logic [20:0]     point_inc;
    logic [CH_W+3:0] chan_ext;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // The header keeps only its first 24 bytes; they enter at the top and move down.
    assign hdr_full = (hdr_cnt_reg < HEADER_KEPT) ? {data_byte, hdr_reg[191:8]} : hdr_reg;
    assign hdr_magic   = hdr_full[31:0];
    assign hdr_version = hdr_full[63:32];
    assign hdr_chans   = hdr_full[95:64];
    assign hdr_points  = hdr_full[127:96];

    assign limit     = (max_points_reg < POINT_CAP) ? max_points_reg : POINT_CAP;
    assign proto_bad = (hdr_magic != FRAME_MAGIC) || (hdr_version != FRAME_VERSION);
    assign param_bad = (hdr_chans != CH_COUNT) || (hdr_points == 32'd0)
                       || (hdr_points > {11'd0, limit});

    assign header_done = accept && (phase_reg == PH_HEADER) && (hdr_cnt_reg == HEADER_LAST);
    assign sample_done = accept && (phase_reg == PH_PAYLOAD) && (smp_cnt_reg == 3'd7);
    assign emit        = header_done || sample_done;

    assign sample_word = {data_byte, shift_reg[63:8]};
    assign point_inc   = {1'b0, point_reg} + 21'd1;
    assign frame_last  = (chan_reg == CH_LAST) && (point_inc >= frame_pts_reg);
    assign chan_ext    = {4'd0, chan_reg};

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_cnt_reg == HEADER_LAST)
                    begin
                        phase_next = (proto_bad || param_bad) ? PH_HALT : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (smp_cnt_reg == 3'd7 && frame_last)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Counters, shift registers and result
    always_comb
    begin
        hdr_cnt_next   = hdr_cnt_reg;
        smp_cnt_next   = smp_cnt_reg;
        chan_next      = chan_reg;
        point_next     = point_reg;
        frame_pts_next = frame_pts_reg;
        hdr_next       = hdr_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        ts_next        = ts_reg;
        pcount_next    = pcount_reg;
        chidx_next     = chidx_reg;
        pidx_next      = pidx_reg;
        bits_next      = bits_reg;
        last_next      = last_reg;

        if (accept && phase_reg == PH_HEADER)
        begin
            hdr_next = hdr_full;
            if (hdr_cnt_reg == HEADER_LAST)
            begin
                hdr_cnt_next = 6'd0;
                kind_next    = proto_bad ? KIND_PROTO_ERR
                             : (param_bad ? KIND_PARAM_ERR : KIND_HEADER);
                ts_next      = 64'd0;
                pcount_next  = 21'd0;
                chidx_next   = 4'd0;
                pidx_next    = 20'd0;
                bits_next    = 64'd0;
                last_next    = 1'b0;
                if (!proto_bad && !param_bad)
                begin
                    ts_next        = hdr_full[191:128];
                    pcount_next    = hdr_points[20:0];
                    frame_pts_next = hdr_points[20:0];
                    chan_next      = '0;
                    point_next     = 20'd0;
                    smp_cnt_next   = 3'd0;
                end
            end
            else
            begin
                hdr_cnt_next = hdr_cnt_reg + 6'd1;
            end
        end

        if (accept && phase_reg == PH_PAYLOAD)
        begin
            shift_next   = sample_word;
            smp_cnt_next = smp_cnt_reg + 3'd1;
            if (smp_cnt_reg == 3'd7)
            begin
                kind_next   = KIND_SAMPLE;
                ts_next     = 64'd0;
                pcount_next = 21'd0;
                chidx_next  = chan_ext[3:0];
                pidx_next   = point_reg;
                bits_next   = sample_word;
                last_next   = frame_last;
                if (frame_last)
                begin
                    hdr_cnt_next = 6'd0;
                    chan_next    = '0;
                    point_next   = 20'd0;
                end
                else if (point_inc >= frame_pts_reg)
                begin
                    point_next = 20'd0;
                    chan_next  = chan_reg + CH_W'(1);
                end
                else
                begin
                    point_next = point_inc[19:0];
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= 6'd0;
            smp_cnt_reg    <= 3'd0;
            chan_reg       <= '0;
            point_reg      <= 20'd0;
            frame_pts_reg  <= 21'd0;
            max_points_reg <= MAX_POINTS_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            smp_cnt_reg    <= smp_cnt_next;
            chan_reg       <= chan_next;
            point_reg      <= point_next;
            frame_pts_reg  <= frame_pts_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                max_points_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg    <= hdr_next;
        shift_reg  <= shift_next;
        kind_reg   <= kind_next;
        ts_reg     <= ts_next;
        pcount_reg <= pcount_next;
        chidx_reg  <= chidx_next;
        pidx_reg   <= pidx_next;
        bits_reg   <= bits_next;
        last_reg   <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign timestamp_ms  = ts_reg;
    assign point_count   = pcount_reg;
    assign channel_index = chidx_reg;
    assign point_index   = pidx_reg;
    assign sample_bits   = bits_reg;
    assign last_of_frame = last_reg;

    // A halted block must never produce another item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALT) |-> !emit)
        else $error("result produced after a header error");

    // Sample assembly restarts cleanly whenever a new header is collected.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (smp_cnt_reg == 3'd0))
        else $error("sample byte count not clear in header phase");

    // An accepted header always announces a nonzero point count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_HEADER) |-> (pcount_reg != 21'd0))
        else $error("header item with zero points");

    // The frame end mark only rides on samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (kind_reg == KIND_SAMPLE))
        else $error("last_of_frame on a non-sample item");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the sample frame deframer, with scoreboard and stimulus.
module testbench;
    import sfd_pkg::*;

    localparam int N_CHANNELS = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO = 1;
    localparam int FILL_ONES = 2;

    typedef enum int {
        BAD_MAGIC,
        BAD_VERSION,
        BAD_BOTH,
        BAD_CHANNELS,
        ZERO_POINTS,
        OVER_LIMIT,
        ZERO_LIMIT
    } fault_t;

    typedef struct {
        kind_t       kind;
        logic [63:0] timestamp_ms;
        logic [20:0] point_count;
        logic [3:0]  channel_index;
        logic [19:0] point_index;
        logic [63:0] sample_bits;
        logic        last_of_frame;
    } frame_result_t;

    // Tracks the frame state byte by byte and holds the results still owed by the block.
    class deframe_checker;
        phase_t          phase;
        int unsigned     hdr_count;
        logic [63:0]     hdr_word [3];
        logic [63:0]     sample_word;
        int unsigned     smp_count;
        int unsigned     chan;
        int unsigned     point;
        int unsigned     frame_points;
        logic [20:0]     max_points;
        frame_result_t   awaited_results [$];
        int              mismatch_count;
        int              header_count;
        int              sample_count;
        int              error_count;

        function new();
            phase = PH_HEADER;
            hdr_count = 0;
            hdr_word = '{64'd0, 64'd0, 64'd0};
            sample_word = 64'd0;
            smp_count = 0;
            chan = 0;
            point = 0;
            frame_points = 0;
            max_points = MAX_POINTS_RST;
            mismatch_count = 0;
            header_count = 0;
            sample_count = 0;
            error_count = 0;
        endfunction

        function void set_limit(input logic [20:0] v);
            max_points = v;
        endfunction

        function void take_byte(input logic [7:0] b);
            frame_result_t r;
            int unsigned   pos;
            int unsigned   lim;
            logic [31:0]   magic;
            logic [31:0]   version;
            logic [31:0]   chans;
            logic [31:0]   points;
            bit            last;
            r.kind = KIND_HEADER;
            r.timestamp_ms = 64'd0;
            r.point_count = 21'd0;
            r.channel_index = 4'd0;
            r.point_index = 20'd0;
            r.sample_bits = 64'd0;
            r.last_of_frame = 1'b0;
            case (phase)
                PH_HEADER:
                begin
                    pos = hdr_count;
                    if (pos < HEADER_KEPT)
                        hdr_word[pos / 8][(pos % 8) * 8 +: 8] = b;
                    hdr_count = pos + 1;
                    if (pos == HEADER_LAST)
                    begin
                        hdr_count = 0;
                        magic = hdr_word[0][31:0];
                        version = hdr_word[0][63:32];
                        chans = hdr_word[1][31:0];
                        points = hdr_word[1][63:32];
                        lim = (max_points < POINT_CAP) ? max_points : POINT_CAP;
                        if (magic != FRAME_MAGIC || version != FRAME_VERSION)
                        begin
                            phase = PH_HALT;
                            r.kind = KIND_PROTO_ERR;
                        end
                        else if (chans != N_CHANNELS || points == 0 || points > lim)
                        begin
                            phase = PH_HALT;
                            r.kind = KIND_PARAM_ERR;
                        end
                        else
                        begin
                            frame_points = points;
                            chan = 0;
                            point = 0;
                            sample_word = 64'd0;
                            smp_count = 0;
                            phase = PH_PAYLOAD;
                            r.timestamp_ms = hdr_word[2];
                            r.point_count = points[20:0];
                        end
                        awaited_results.push_back(r);
                    end
                end
                PH_PAYLOAD:
                begin
                    sample_word[smp_count * 8 +: 8] = b;
                    smp_count++;
                    if (smp_count == 8)
                    begin
                        smp_count = 0;
                        last = (chan == N_CHANNELS - 1) && (point + 1 >= frame_points);
                        r.kind = KIND_SAMPLE;
                        r.channel_index = chan[3:0];
                        r.point_index = point[19:0];
                        r.sample_bits = sample_word;
                        r.last_of_frame = last;
                        awaited_results.push_back(r);
                        if (last)
                        begin
                            phase = PH_HEADER;
                            hdr_count = 0;
                            chan = 0;
                            point = 0;
                        end
                        else
                        begin
                            point++;
                            if (point >= frame_points)
                            begin
                                point = 0;
                                chan++;
                            end
                        end
                        sample_word = 64'd0;
                    end
                end
                default:
                    ;  // Halted after an error: the byte is dropped.
            endcase
        endfunction

        function void check_result(input frame_result_t got);
            frame_result_t exp;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result kind %0d arrived with nothing expected", $time, got.kind);
                mismatch_count++;
                return;
            end
            exp = awaited_results.pop_front();
            case (got.kind)
                KIND_HEADER: header_count++;
                KIND_SAMPLE: sample_count++;
                default: error_count++;
            endcase
            if (got.kind !== exp.kind)
                $display("%0t: kind expected %0d actual %0d", $time, exp.kind, got.kind);
            if (got.timestamp_ms !== exp.timestamp_ms)
                $display("%0t: timestamp_ms expected %h actual %h",
                         $time, exp.timestamp_ms, got.timestamp_ms);
            if (got.point_count !== exp.point_count)
                $display("%0t: point_count expected %0d actual %0d",
                         $time, exp.point_count, got.point_count);
            if (got.channel_index !== exp.channel_index)
                $display("%0t: channel_index expected %0d actual %0d",
                         $time, exp.channel_index, got.channel_index);
            if (got.point_index !== exp.point_index)
                $display("%0t: point_index expected %0d actual %0d",
                         $time, exp.point_index, got.point_index);
            if (got.sample_bits !== exp.sample_bits)
                $display("%0t: sample_bits expected %h actual %h",
                         $time, exp.sample_bits, got.sample_bits);
            if (got.last_of_frame !== exp.last_of_frame)
                $display("%0t: last_of_frame expected %0d actual %0d",
                         $time, exp.last_of_frame, got.last_of_frame);
            if (got.kind !== exp.kind || got.timestamp_ms !== exp.timestamp_ms ||
                got.point_count !== exp.point_count ||
                got.channel_index !== exp.channel_index ||
                got.point_index !== exp.point_index || got.sample_bits !== exp.sample_bits ||
                got.last_of_frame !== exp.last_of_frame)
                mismatch_count++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [20:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [63:0] timestamp_ms;
    logic [20:0] point_count;
    logic [3:0]  channel_index;
    logic [19:0] point_index;
    logic [63:0] sample_bits;
    logic        last_of_frame;

    deframe_checker frame_sb = new();
    frame_result_t  seen;
    int             bytes_sent = 0;
    bit             calm = 1'b0;
    bit             hold_request = 1'b0;
    int unsigned    eff_limit = MAX_POINTS_RST;
    fault_t         fault;

    sample_frame_deframer #(
        .CHANNELS(N_CHANNELS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .timestamp_ms(timestamp_ms),
        .point_count(point_count),
        .channel_index(channel_index),
        .point_index(point_index),
        .sample_bits(sample_bits),
        .last_of_frame(last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3600000;
        $display("Timeout: the block stopped making progress.");
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.kind = kind_t'(kind);
            seen.timestamp_ms = timestamp_ms;
            seen.point_count = point_count;
            seen.channel_index = channel_index;
            seen.point_index = point_index;
            seen.sample_bits = sample_bits;
            seen.last_of_frame = last_of_frame;
            frame_sb.check_result(seen);
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] fill_byte(input int fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one byte item from a falling edge and returns at the falling edge after it is taken.
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frame_sb.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [31:0] magic, input logic [31:0] version,
                              input logic [31:0] chans, input logic [31:0] points,
                              input logic [63:0] stamp, input int fill,
                              input bit with_payload);
        logic [127:0] head;
        int unsigned  total;
        int unsigned  i;
        head = {points, chans, version, magic};
        for (i = 0; i < 16; i++)
            push_byte(head[i * 8 +: 8]);
        for (i = 0; i < 8; i++)
            push_byte(stamp[i * 8 +: 8]);
        for (i = 0; i < 20; i++)
            push_byte(fill_byte(fill));
        total = with_payload ? points * N_CHANNELS * 8 : 0;
        for (i = 0; i < total; i++)
            push_byte(fill_byte(fill));
    endtask

    // Stops offering items until every owed result has come out, then lets the block settle.
    task automatic settle();
        in_valid <= 1'b0;
        while (frame_sb.awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [20:0] v);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        frame_sb.set_limit(v);
        eff_limit = (v < POINT_CAP) ? v : POINT_CAP;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] magic;
        logic [31:0] version;
        logic [31:0] chans;
        logic [31:0] points;
        int unsigned pts;
        int          frames;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 21'd0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        frames = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frames: all-zero and all-one content, one point each, the second at its limit.
        send_frame(FRAME_MAGIC, FRAME_VERSION, N_CHANNELS, 1, 64'd0, FILL_ZERO, 1'b1);
        write_limit(21'd1);
        send_frame(FRAME_MAGIC, FRAME_VERSION, N_CHANNELS, 1, '1, FILL_ONES, 1'b1);
        write_limit(POINT_CAP);

        // The first random frame runs into a long result hold-off, so the input stalls.
        hold_request = 1'b1;
        while (bytes_sent < 1330)
        begin
            if (frames % 3 == 2)
            begin
                case ($urandom_range(0, 4))
                    0: write_limit(21'd1);
                    1: write_limit(21'd2);
                    2: write_limit(21'($urandom_range(2, 1048576)));
                    3: write_limit(POINT_CAP);
                    default: write_limit(21'($urandom_range(1048577, 2097151)));
                endcase
            end
            pts = $urandom_range(1, (eff_limit < 2) ? 1 : 2);
            send_frame(FRAME_MAGIC, FRAME_VERSION, N_CHANNELS, pts, {$urandom, $urandom},
                       FILL_RANDOM, 1'b1);
            frames++;
            if (bytes_sent > 1050)
                calm = 1'b1;
        end
        calm = 1'b1;

        // One bad header ends the useful life of the block; everything after it is dropped.
        fault = fault_t'($urandom_range(0, 6));
        magic = FRAME_MAGIC;
        version = FRAME_VERSION;
        chans = N_CHANNELS;
        points = 1;
        case (fault)
            BAD_MAGIC:
                magic = FRAME_MAGIC ^ ($urandom | 32'h8000_0000);
            BAD_VERSION:
                version = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom | 32'd2);
            BAD_BOTH:
            begin
                magic = FRAME_MAGIC ^ ($urandom | 32'h8000_0000);
                chans = 0;
                points = 0;
            end
            BAD_CHANNELS:
                chans = ($urandom_range(0, 1) == 0) ? N_CHANNELS + 1 :
                        (($urandom_range(0, 1) == 0) ? N_CHANNELS - 1 : ($urandom | 32'h100));
            ZERO_POINTS:
                points = 0;
            OVER_LIMIT:
            begin
                case ($urandom_range(0, 3))
                    0: write_limit(21'd1);
                    1: write_limit(POINT_CAP);
                    2: write_limit(21'h1F_FFFF);
                    default: write_limit(21'($urandom_range(1, 1048576)));
                endcase
                points = ($urandom_range(0, 1) == 0) ? eff_limit + 1 : 32'hFFFF_FFFF;
            end
            default:
                write_limit(21'd0);
        endcase
        send_frame(magic, version, chans, points, {$urandom, $urandom}, FILL_RANDOM, 1'b0);
        send_frame(FRAME_MAGIC, FRAME_VERSION, N_CHANNELS, 1, {$urandom, $urandom},
                   FILL_RANDOM, 1'b0);
        repeat (16) push_byte(fill_byte(FILL_RANDOM));

        settle();
        repeat (16) @(negedge clk);
        $display("Run covered %0d byte items in %0d random frames and a final bad header (%s).",
                 bytes_sent, frames, fault.name());
        $display("Checked %0d header, %0d sample and %0d error results.",
                 frame_sb.header_count, frame_sb.sample_count, frame_sb.error_count);
        if (frame_sb.mismatch_count == 0 && frame_sb.awaited_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sfd_pkg.sv
sv/sample_frame_deframer.sv
sim/testbench.sv
